[design/abpr_pkg.sv]
// Package for the attribute bitmap pixel renderer.
// Holds the screen memory geometry, register and mode codes, reset values
// and the palette lookup. No dependencies.
package abpr_pkg;

  localparam int MEM_DEPTH     = 6912;
  localparam int MEM_AW        = 13;
  localparam int DISPLAY_LINES = 192;

  localparam int PALETTE_W = 48;
  localparam int COLOUR_W  = 6;

  localparam logic [2:0]           BORDER_RESET = 3'd0;
  localparam logic [7:0]           CROP_RESET   = 8'd23;
  localparam logic [9:0]           FIRST_RESET  = 10'd0;
  localparam logic [PALETTE_W-1:0] PALETTE_RESET = 48'hFCF3CC30C0C0;

  // Attribute area starts at 6144: top three address bits 110.
  localparam logic [2:0] ATTRIB_AREA_HI = 3'b110;

  typedef enum logic [1:0] {
    REG_BORDER_COLOUR      = 2'd0,
    REG_CROP_OFFSET        = 2'd1,
    REG_FIRST_DISPLAY_LINE = 2'd2,
    REG_PALETTE            = 2'd3
  } reg_index_t;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  function automatic logic [COLOUR_W-1:0] palette_entry(
    input logic [PALETTE_W-1:0] pal,
    input logic [2:0]           idx
  );
    palette_entry = pal[COLOUR_W*idx +: COLOUR_W];
  endfunction

endpackage

[design/abpr_ram.sv]
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module abpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6912
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/attribute_bitmap_pixel_render.sv]
// Attribute bitmap pixel renderer, top level.
// Depends on abpr_pkg and abpr_ram.
//
//   channel   signals                              direction
//   item in   start, busy, mode, address, data,    in (busy out)
//             line, column
//   result    done, colour, is_border              out
//   config    cfg_write, cfg_index, cfg_data       in
//
// An item is taken every cycle; busy is always low. A render item gives its
// result through the address stage, the memory read and the colour select,
// which are registered in turn. A write item gives no result. Reset clears
// the stage valid bits and the registers; the screen memory is not cleared.
// The receiver cannot stall the pipeline.
module attribute_bitmap_pixel_render
  import abpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode,
  input  logic [12:0]          address,
  input  logic [7:0]           data,
  input  logic [9:0]           line,
  input  logic [7:0]           column,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [PALETTE_W-1:0] cfg_data,
  output logic                 done,
  output logic [COLOUR_W-1:0]  colour,
  output logic                 is_border
);

  logic [2:0]           border_colour;
  logic [7:0]           crop_offset;
  logic [9:0]           first_display_line;
  logic [PALETTE_W-1:0] palette;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_colour      <= BORDER_RESET;
      crop_offset        <= CROP_RESET;
      first_display_line <= FIRST_RESET;
      palette            <= PALETTE_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_BORDER_COLOUR:      border_colour      <= cfg_data[2:0];
        REG_CROP_OFFSET:        crop_offset        <= cfg_data[7:0];
        REG_FIRST_DISPLAY_LINE: first_display_line <= cfg_data[9:0];
        REG_PALETTE:            palette            <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: window test and address generation.
  logic [9:0] sy;
  logic [8:0] sx;
  logic       in_window;
  logic       border_next;

  assign sy          = line - first_display_line;
  assign sx          = {1'b0, column} + {1'b0, crop_offset};
  assign in_window   = (line >= first_display_line) && (sy < 10'(DISPLAY_LINES));
  assign border_next = !in_window || sx[8];

  logic              s1_valid;
  logic              s1_mode;
  logic [MEM_AW-1:0] s1_waddr;
  logic [7:0]        s1_wdata;
  logic              s1_border;
  logic [MEM_AW-1:0] s1_bmp_addr;
  logic [MEM_AW-1:0] s1_attr_addr;
  logic [2:0]        s1_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_mode      <= mode;
    s1_waddr     <= address;
    s1_wdata     <= data;
    s1_border    <= border_next;
    s1_bmp_addr  <= {sy[7:6], sy[2:0], sy[5:3], sx[7:3]};
    s1_attr_addr <= {ATTRIB_AREA_HI, sy[7:3], sx[7:3]};
    s1_bit       <= sx[2:0];
  end

  // Stage 2: screen memory access. Writes and reads share this stage, so
  // a render sees every write taken before it.
  logic       mem_we;
  logic [7:0] bmp_byte;
  logic [7:0] attr_byte;

  assign mem_we = s1_valid && (s1_mode == MODE_WRITE) && (s1_waddr < 13'(MEM_DEPTH));

  abpr_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_screen (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (s1_waddr),
    .wdata   (s1_wdata),
    .raddr_a (s1_bmp_addr),
    .rdata_a (bmp_byte),
    .raddr_b (s1_attr_addr),
    .rdata_b (attr_byte)
  );

  logic       s2_valid;
  logic       s2_border;
  logic [2:0] s2_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1_mode == MODE_RENDER);
    end
    s2_border <= s1_border;
    s2_bit    <= s1_bit;
  end

  // Stage 3: ink or paper select, palette lookup and output register.
  logic       is_ink;
  logic [2:0] idx;

  assign is_ink = bmp_byte[3'd7 - s2_bit];

  always_comb begin
    if (s2_border) begin
      idx = border_colour;
    end else if (is_ink) begin
      idx = attr_byte[2:0];
    end else begin
      idx = attr_byte[5:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    colour    <= palette_entry(palette, idx);
    is_border <= s2_border;
  end

`ifndef SYNTHESIS
  a_render_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_RENDER) |-> ##3 done)
    else $error("render item gave no result");

  a_write_gives_none: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_WRITE) |-> ##3 !done)
    else $error("write item gave a result");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");
`endif

endmodule

[sim/tb_attribute_bitmap_pixel_render.sv]
// Self-checking testbench for attribute_bitmap_pixel_render.
// Keeps its own copy of the screen memory and registers, predicts each pixel
// item, and compares results in order. Depends on abpr_pkg and the block RTL.
module tb_attribute_bitmap_pixel_render;
  import abpr_pkg::*;

  localparam int ATTRIB_START = 6144;
  localparam int PIPE_SETTLE  = 6;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic                is_border;
  } pixel_t;

  typedef struct {
    bit          in_area;
    logic [12:0] bm_addr;
    logic [12:0] at_addr;
    logic [2:0]  bit_sel;
  } pixel_loc_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 mode = MODE_WRITE;
  logic [12:0]          address = '0;
  logic [7:0]           data = '0;
  logic [9:0]           line = '0;
  logic [7:0]           column = '0;
  logic                 cfg_write = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [PALETTE_W-1:0] cfg_data = '0;
  logic                 done;
  logic [COLOUR_W-1:0]  colour;
  logic                 is_border;

  logic [2:0]           border_cfg = BORDER_RESET;
  logic [7:0]           crop_cfg   = CROP_RESET;
  logic [9:0]           first_cfg  = FIRST_RESET;
  logic [PALETTE_W-1:0] pal_cfg    = PALETTE_RESET;

  logic [7:0] screen_copy [MEM_DEPTH];
  bit         screen_written [MEM_DEPTH];
  pixel_t     pixel_queue [$];
  int         mismatch_count = 0;
  int         items_sent = 0;
  bit         gaps_on = 1'b1;

  attribute_bitmap_pixel_render DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .address(address),
    .data(data),
    .line(line),
    .column(column),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .colour(colour),
    .is_border(is_border)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic pixel_loc_t locate_pixel(input logic [9:0] ln, input logic [7:0] col);
    pixel_loc_t loc;
    int sx;
    int sy;
    int row;
    sx = int'(col) + int'(crop_cfg);
    sy = int'(ln) - int'(first_cfg);
    loc.in_area = (sy >= 0) && (sy < DISPLAY_LINES) && (sx < 256);
    row = ((sy & 'h07) << 8) | ((sy & 'h38) << 2) | ((sy & 'hC0) << 5);
    loc.bm_addr = 13'(row + (sx >> 3));
    loc.at_addr = 13'(ATTRIB_START + (sy >> 3) * 32 + (sx >> 3));
    loc.bit_sel = 3'(7 - (sx & 7));
    return loc;
  endfunction

  function automatic logic [PALETTE_W-1:0] random_palette();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[PALETTE_W-1:0];
  endfunction

  task automatic send_item(input logic m, input logic [12:0] a, input logic [7:0] d,
                           input logic [9:0] ln, input logic [7:0] col);
    pixel_loc_t loc;
    pixel_t     px;
    logic [7:0] at_byte;
    logic [2:0] idx;
    start <= 1'b1;
    mode <= m;
    address <= a;
    data <= d;
    line <= ln;
    column <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (m == MODE_WRITE) begin
      if (a < MEM_DEPTH) begin
        screen_copy[a] = d;
        screen_written[a] = 1'b1;
      end
    end else begin
      loc = locate_pixel(ln, col);
      if (!loc.in_area) begin
        px.colour = pal_cfg[border_cfg*COLOUR_W +: COLOUR_W];
        px.is_border = 1'b1;
      end else begin
        at_byte = screen_copy[loc.at_addr];
        idx = screen_copy[loc.bm_addr][loc.bit_sel] ? at_byte[2:0] : at_byte[5:3];
        px.colour = pal_cfg[idx*COLOUR_W +: COLOUR_W];
        px.is_border = 1'b0;
      end
      pixel_queue.push_back(px);
    end
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic write_byte(input logic [12:0] a, input logic [7:0] d);
    send_item(MODE_WRITE, a, d, 10'($urandom), 8'($urandom));
  endtask

  task automatic render_pixel(input logic [9:0] ln, input logic [7:0] col);
    pixel_loc_t loc;
    loc = locate_pixel(ln, col);
    if (loc.in_area) begin
      if (!screen_written[loc.bm_addr]) write_byte(loc.bm_addr, 8'($urandom));
      if (!screen_written[loc.at_addr]) write_byte(loc.at_addr, 8'($urandom));
    end
    send_item(MODE_RENDER, 13'($urandom), 8'($urandom), ln, col);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [PALETTE_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_BORDER_COLOUR:      border_cfg = value[2:0];
      REG_CROP_OFFSET:        crop_cfg = value[7:0];
      REG_FIRST_DISPLAY_LINE: first_cfg = value[9:0];
      REG_PALETTE:            pal_cfg = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [2:0] border, input logic [7:0] crop,
                                input logic [9:0] first, input logic [PALETTE_W-1:0] pal);
    settle();
    write_reg(REG_BORDER_COLOUR, PALETTE_W'(border));
    write_reg(REG_CROP_OFFSET, PALETTE_W'(crop));
    write_reg(REG_FIRST_DISPLAY_LINE, PALETTE_W'(first));
    write_reg(REG_PALETTE, pal);
    cfg_write <= 1'b0;
  endtask

  task automatic test_reset_config();
    render_pixel(10'd0, 8'd0);
    render_pixel(10'd0, 8'd232);
    render_pixel(10'd0, 8'd233);
    render_pixel(10'd192, 8'd5);
    render_pixel(10'd1023, 8'd255);
  endtask

  task automatic test_pixel_select();
    apply_settings(3'd7, 8'd0, 10'd0, random_palette());
    write_byte(13'd0, 8'h80);
    write_byte(13'd6144, 8'h3A);
    write_byte(13'd6143, 8'h01);
    write_byte(13'd6911, 8'hC5);
    write_byte(13'd1, 8'h00);
    render_pixel(10'd0, 8'd0);
    render_pixel(10'd0, 8'd1);
    render_pixel(10'd191, 8'd255);
    render_pixel(10'd191, 8'd254);
    render_pixel(10'd0, 8'd8);
    render_pixel(10'd192, 8'd0);
    write_byte(13'd6912, 8'hFF);
    write_byte(13'd8191, 8'hFF);
    render_pixel(10'd0, 8'd0);
    render_pixel(10'd191, 8'd255);
  endtask

  task automatic test_window_limits();
    apply_settings(3'd0, 8'd255, 10'd1023, {PALETTE_W{1'b1}});
    render_pixel(10'd1023, 8'd0);
    render_pixel(10'd1022, 8'd0);
    render_pixel(10'd1023, 8'd1);
    apply_settings(3'd6, 8'd0, 10'd900, random_palette());
    render_pixel(10'd1023, 8'd200);
    render_pixel(10'd899, 8'd5);
    render_pixel(10'd0, 8'd5);
    render_pixel(10'd50, 8'd5);
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    int span;
    logic [9:0] ln;
    logic [7:0] col;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        write_byte(13'($urandom_range(0, 8191)), 8'($urandom));
      end else if (pick < 25) begin
        render_pixel(10'($urandom), 8'($urandom));
      end else begin
        span = 1023 - int'(first_cfg);
        if (span > DISPLAY_LINES - 1) span = DISPLAY_LINES - 1;
        ln = 10'(int'(first_cfg) + $urandom_range(0, span));
        col = 8'($urandom_range(0, 255 - int'(crop_cfg)));
        render_pixel(ln, col);
      end
    end
  endtask

  task automatic test_random_phases();
    apply_settings(BORDER_RESET, CROP_RESET, FIRST_RESET, PALETTE_RESET);
    run_random(170);
    apply_settings(3'd7, 8'd0, 10'd0, random_palette());
    run_random(170);
    apply_settings(3'd3, 8'd255, 10'd1023, {PALETTE_W{1'b1}});
    run_random(170);
    apply_settings(3'($urandom), 8'd128, 10'd832, random_palette());
    run_random(170);
    apply_settings(3'($urandom), 8'($urandom), 10'($urandom), '0);
    run_random(170);
    apply_settings(3'($urandom), 8'($urandom), 10'($urandom_range(0, 400)), random_palette());
    run_random(170);
    apply_settings(3'd5, 8'd40, 10'd100, random_palette());
    run_random(170);
    apply_settings(3'($urandom), 8'($urandom_range(0, 60)), 10'($urandom_range(0, 300)),
                   random_palette());
    gaps_on = 1'b0;
    run_random(170);
  endtask

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && done) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch($sformatf("result with none expected, colour %h", colour));
      end else begin
        exp_px = pixel_queue.pop_front();
        if (colour !== exp_px.colour) begin
          report_mismatch($sformatf("colour %h, expected %h", colour, exp_px.colour));
        end
        if (is_border !== exp_px.is_border) begin
          report_mismatch($sformatf("is_border %b, expected %b", is_border, exp_px.is_border));
        end
      end
    end
  end

  initial begin
    int guard;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_pixel_select();
    test_window_limits();
    test_random_phases();
    start <= 1'b0;
    guard = 0;
    while (pixel_queue.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    if (pixel_queue.size() != 0) begin
      report_mismatch($sformatf("%0d pixel results never arrived", pixel_queue.size()));
    end
    repeat (PIPE_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_attribute_bitmap_pixel_render: done, clean");
    end else begin
      $display("tb_attribute_bitmap_pixel_render: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_attribute_bitmap_pixel_render: done, errors");
    $finish;
  end

endmodule
